### rtl/class_selective_fifo_unit_macros.svh
// Assertion macros shared by the class-selective queue RTL.
`ifndef CLASS_SELECTIVE_FIFO_UNIT_MACROS_SVH
`define CLASS_SELECTIVE_FIFO_UNIT_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define CSF_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check that cons holds in the cycle after ante.
`define CSF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/csf_pkg.sv
// Shared types and codes for the class-selective queue.
`timescale 1ns / 1ps
`default_nettype none

package csf_pkg;

  localparam int QUEUE_DEPTH_DEFAULT = 16;
  localparam int CLASS_W  = 8;
  localparam int HANDLE_W = 16;

  // Request codes
  localparam logic [1:0] REQ_ENQ       = 2'd0;
  localparam logic [1:0] REQ_DEQ_ANY   = 2'd1;
  localparam logic [1:0] REQ_DEQ_CLASS = 2'd2;

  // Status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_EMPTY   = 2'd1;
  localparam logic [1:0] ST_NOMATCH = 2'd2;
  localparam logic [1:0] ST_FULL    = 2'd3;

  // One stored queue entry
  typedef struct packed {
    logic [CLASS_W-1:0]  cls;
    logic [HANDLE_W-1:0] hdl;
  } entry_t;

endpackage

`default_nettype wire

### rtl/csf_ram.sv
// Entry store: one write port, one read port with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module csf_ram #(
  parameter int DEPTH = csf_pkg::QUEUE_DEPTH_DEFAULT,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic            clk,
  input  wire logic            wr_en,
  input  wire logic [AW-1:0]   wr_addr,
  input  wire csf_pkg::entry_t wr_data,
  input  wire logic            rd_en,
  input  wire logic [AW-1:0]   rd_addr,
  output csf_pkg::entry_t      rd_data
);

  csf_pkg::entry_t mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port, registered read data
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

### rtl/class_selective_fifo_unit.sv
// Top level: arrival-ordered queue with oldest and class-selective dequeue.
// Enqueue, full, empty and no-op requests post from S_PUSH; dequeue oldest reads the
// head in S_TAKE first; class dequeue scans in S_SCAN and closes the gap in S_SHIFT,
// each paced by the single store read port (one entry scanned or moved a cycle).
// One request at a time: req_stall stays high until the result is posted.
// Synchronous reset empties the queue; entry contents stay undefined.
`timescale 1ns / 1ps
`default_nettype none

`include "class_selective_fifo_unit_macros.svh"

module class_selective_fifo_unit #(
  parameter int QUEUE_DEPTH = csf_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         req_valid,
  output logic                              req_stall,
  input  wire logic [1:0]                   req_type,
  input  wire logic [csf_pkg::CLASS_W-1:0]  entry_class,
  input  wire logic [csf_pkg::HANDLE_W-1:0] entry_handle,
  output logic                              res_valid,
  input  wire logic                         res_stall,
  output logic [1:0]                        status,
  output logic [csf_pkg::CLASS_W-1:0]       out_class,
  output logic [csf_pkg::HANDLE_W-1:0]      out_handle
);

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);
  localparam logic [CW:0]   DEPTH_W = (CW+1)'(QUEUE_DEPTH);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_TAKE  = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_SHIFT = 3'd3;
  localparam logic [2:0] S_PUSH  = 3'd4;

  logic [2:0]    state, state_next;
  logic [AW-1:0] head, head_next;
  logic [CW-1:0] count, count_next;
  logic [CW-1:0] rd_pos, rd_pos_next;
  logic [CW-1:0] rpos, rpos_next;
  logic          rv, rv_next;
  logic [csf_pkg::CLASS_W-1:0] match_class, match_class_next;

  logic [1:0]                   pend_status, pend_status_next;
  logic [csf_pkg::CLASS_W-1:0]  pend_class, pend_class_next;
  logic [csf_pkg::HANDLE_W-1:0] pend_handle, pend_handle_next;

  logic            wr_en, rd_en;
  logic [AW-1:0]   wr_addr, rd_addr;
  csf_pkg::entry_t wr_data, rd_data;

  logic accept, out_free;

  // Map a position in arrival order to a store address
  function automatic logic [AW-1:0] phys(input logic [AW-1:0] base,
                                         input logic [CW-1:0] pos);
    logic [CW:0] sum;
    sum = {{(CW+1-AW){1'b0}}, base} + {1'b0, pos};
    if (sum >= DEPTH_W) begin
      sum = sum - DEPTH_W;
    end
    return sum[AW-1:0];
  endfunction

  csf_ram #(.DEPTH(QUEUE_DEPTH)) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign req_stall = (state != S_IDLE);
  assign accept    = req_valid && !req_stall;
  assign out_free  = !res_valid || !res_stall;

  // Sequence one request: decode, take or scan, close the gap, post the result
  always_comb begin
    state_next       = state;
    head_next        = head;
    count_next       = count;
    rd_pos_next      = rd_pos;
    rpos_next        = rpos;
    rv_next          = rv;
    match_class_next = match_class;
    pend_status_next = pend_status;
    pend_class_next  = pend_class;
    pend_handle_next = pend_handle;
    wr_en            = 1'b0;
    wr_addr          = phys(head, count);
    wr_data          = '{cls: entry_class, hdl: entry_handle};
    rd_en            = 1'b0;
    rd_addr          = phys(head, rd_pos);

    unique case (state)
      S_IDLE: begin
        if (accept) begin
          pend_status_next = csf_pkg::ST_OK;
          pend_class_next  = '0;
          pend_handle_next = '0;
          state_next       = S_PUSH;
          case (req_type)
            csf_pkg::REQ_ENQ: begin
              if (count == DEPTH_C) begin
                pend_status_next = csf_pkg::ST_FULL;
              end else begin
                wr_en      = 1'b1;
                count_next = count + 1'b1;
              end
            end
            csf_pkg::REQ_DEQ_ANY: begin
              if (count == '0) begin
                pend_status_next = csf_pkg::ST_EMPTY;
              end else begin
                rd_en      = 1'b1;
                rd_addr    = head;
                state_next = S_TAKE;
              end
            end
            csf_pkg::REQ_DEQ_CLASS: begin
              if (count == '0) begin
                pend_status_next = csf_pkg::ST_EMPTY;
              end else begin
                match_class_next = entry_class;
                rd_pos_next      = '0;
                rv_next          = 1'b0;
                state_next       = S_SCAN;
              end
            end
            default: begin
            end
          endcase
        end
      end

      S_TAKE: begin
        pend_class_next  = rd_data.cls;
        pend_handle_next = rd_data.hdl;
        head_next        = phys(head, CW'(1));
        count_next       = count - 1'b1;
        state_next       = S_PUSH;
      end

      S_SCAN: begin
        if (rv && rd_data.cls == match_class) begin
          // Hit: remember the entry, then move the later ones up
          pend_class_next  = rd_data.cls;
          pend_handle_next = rd_data.hdl;
          rd_pos_next      = rpos + 1'b1;
          rv_next          = 1'b0;
          state_next       = S_SHIFT;
        end else if (rv && (rpos + 1'b1) == count) begin
          pend_status_next = csf_pkg::ST_NOMATCH;
          rv_next          = 1'b0;
          state_next       = S_PUSH;
        end else if (rd_pos < count) begin
          rd_en       = 1'b1;
          rd_pos_next = rd_pos + 1'b1;
          rpos_next   = rd_pos;
          rv_next     = 1'b1;
        end else begin
          rv_next = 1'b0;
        end
      end

      S_SHIFT: begin
        // Read position k, write it back at k - 1 in the next cycle
        if (rd_pos < count) begin
          rd_en       = 1'b1;
          rd_pos_next = rd_pos + 1'b1;
          rpos_next   = rd_pos;
          rv_next     = 1'b1;
        end else begin
          rv_next = 1'b0;
        end
        if (rv) begin
          wr_en   = 1'b1;
          wr_addr = phys(head, rpos - 1'b1);
          wr_data = rd_data;
        end
        if (rd_pos >= count && !rv) begin
          count_next = count - 1'b1;
          state_next = S_PUSH;
        end
      end

      S_PUSH: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      head  <= '0;
      count <= '0;
      rv    <= 1'b0;
    end else begin
      state <= state_next;
      head  <= head_next;
      count <= count_next;
      rv    <= rv_next;
    end
  end

  // Working and pending-result registers
  always_ff @(posedge clk) begin
    rd_pos      <= rd_pos_next;
    rpos        <= rpos_next;
    match_class <= match_class_next;
    pend_status <= pend_status_next;
    pend_class  <= pend_class_next;
    pend_handle <= pend_handle_next;
  end

  // Output register: load from the pending result, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (state == S_PUSH && out_free) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_PUSH && out_free) begin
      status     <= pend_status;
      out_class  <= pend_class;
      out_handle <= pend_handle;
    end
  end

  `CSF_ASSERT_NOW(a_count_bound, 1'b1, count <= DEPTH_C, "fill count above depth")
  `CSF_ASSERT_NEXT(a_accept_busy, accept, state != S_IDLE, "request accepted without work")
  `CSF_ASSERT_NOW(a_shift_pos, state == S_SHIFT && rv, rpos != '0, "gap close at head slot")
  `CSF_ASSERT_NOW(a_fail_zero, res_valid && status != csf_pkg::ST_OK && out_class != '0, 1'b0, "failed request with class")

endmodule

`default_nettype wire
